// ===== hdl/sgtm_pkg.sv =====
package sgtm_pkg;

    // Temperature bounds in Q8.8 (+-100 degrees) and idle bound
    localparam logic signed [15:0] TEMP_MAX = 16'sd25600;
    localparam logic signed [15:0] TEMP_MIN = -16'sd25600;
    localparam logic [5:0]         IDLE_MAX = 6'd50;

    // Register reset values
    localparam logic signed [15:0] RESET_LOW   = -16'sd25600;
    localparam logic signed [15:0] RESET_HIGH  = 16'sd25600;
    localparam logic [5:0]         RESET_IDLE  = 6'd50;
    localparam logic signed [15:0] RESET_START = 16'sd0;
    localparam logic [2:0]         RESET_ROWS  = 3'd4;
    localparam logic [3:0]         RESET_COLS  = 4'd8;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_LOW_LIMIT   = 3'd0,
        REG_HIGH_LIMIT  = 3'd1,
        REG_IDLE_LIMIT  = 3'd2,
        REG_START_TEMP  = 3'd3,
        REG_GRID_ROWS   = 3'd4,
        REG_GRID_COLS   = 3'd5
    } reg_idx_t;

    // Operation codes
    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_UPDATE = 3'd1,
        OP_TICK   = 3'd2,
        OP_SCAN   = 3'd3,
        OP_SWAP   = 3'd4
    } op_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_HIGH     = 2'd0,
        KIND_LOW      = 2'd1,
        KIND_INACTIVE = 2'd2,
        KIND_DONE     = 2'd3
    } kind_t;

    // What the processing step does with an entry read from the sensor memory
    typedef enum logic [1:0] {
        WM_UPDATE = 2'd0,
        WM_TICK   = 2'd1,
        WM_SCAN   = 2'd2
    } walk_mode_t;

    // Swap sequence steps
    typedef enum logic [2:0] {
        SW_NONE = 3'd0,
        SW_RDA  = 3'd1,
        SW_RDB  = 3'd2,
        SW_WRA  = 3'd3,
        SW_WRB  = 3'd4
    } swap_step_t;

    // One sensor entry in memory
    typedef struct packed {
        logic              active;
        logic [5:0]        idle;
        logic signed [15:0] temp;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic       load_item;  // capture the input transaction
        logic       latch_cfg;  // clear: check and latch grid settings
        logic       rd_en;      // read entry at (row, col)
        logic       wr_fill;    // fill entry at (row, col)
        logic       fill_zero;  // fill with reset contents instead of start temperature
        logic [2:0] row;
        logic [2:0] col;
        logic       proc;       // process the registered read entry at (p_row, p_col)
        walk_mode_t mode;
        logic [2:0] p_row;
        logic [2:0] p_col;
        swap_step_t swap;
        logic       emit_done;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic       out_free;   // output register can take a result this cycle
        logic       cfg_ok;     // configuration registers pass the clear check
        op_t        op;
        logic       a_in;       // position a inside the grid
        logic       b_in;       // position b inside the grid
        logic [2:0] row_a;
        logic [2:0] col_a;
        logic [3:0] g_rows;
        logic [3:0] g_cols;
    } status_t;

endpackage

// ===== hdl/sensor_grid_threshold_monitor.sv =====
// Sensor grid threshold monitor.
// Input channel (s_): one transaction is one operation, chosen by s_tuser:
// clear, update, tick, scan or swap. Output channel (m_): alert transactions
// in row-major sensor order, then one done transaction with m_tlast high.
// Configuration: cfg_wr_en writes cfg_wr_data to register cfg_index;
// settings take effect at the next clear. Write only while idle.
// Sequencing: the block takes one operation at a time. Tick and scan read the
// sensor memory once per sensor in the grid, one read per cycle while the
// output register is not stalled. Clear fills all MAX_ROWS*MAX_COLS entries
// through the single write port.
// Reset: aresetn is synchronous, active low. After reset a clearing pass loads
// every sensor with zero, active, counter zero; s_tready stays low meanwhile.
// Grid settings come up as 4 x 8 with limits +-100 degrees and idle limit 50.
// Stall: a result waits in the output register while m_tready is low; the
// sensor walk holds until it is taken, so nothing is lost.
module sensor_grid_threshold_monitor #(
    parameter int MAX_ROWS = 4,
    parameter int MAX_COLS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wr_data,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // row_a[2:0], col_a[5:3], reading[21:6], row_b[24:22], col_b[27:25]
    input  logic [2:0]  s_tuser,   // op[2:0]
    // output channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // alert_row[2:0], alert_col[5:3], alert_temp[21:6], swap_ok[22]
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast    // last
);

    sgtm_pkg::cmd_t    cmd;
    sgtm_pkg::status_t status;

    sgtm_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sgtm_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

`ifndef ASSERT_OFF
    // one operation at a time: ready drops after an accepted transaction
    a_one_op: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an operation is in progress");

    // the done transaction, and only it, closes a run
    a_last_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == sgtm_pkg::KIND_DONE)))
        else $error("m_tlast does not match a done transaction");

    // no memory traffic from a walk while the block is idle
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !cmd.proc && !cmd.rd_en && !cmd.wr_fill)
        else $error("sensor memory accessed while idle");

    // results are only loaded when the output register can take them
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.proc || cmd.emit_done) |-> status.out_free)
        else $error("result loaded while output register is stalled");
`endif

endmodule

// ===== hdl/sgtm_ram.sv =====
module sgtm_ram #(
    parameter int WIDTH = 23,
    parameter int DEPTH = 32
) (
    input  logic                                         aclk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port, registered read that holds while re is low
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/sgtm_ctrl.sv =====
module sgtm_ctrl #(
    parameter int MAX_ROWS = 4,
    parameter int MAX_COLS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  sgtm_pkg::status_t status,
    output sgtm_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_SWEEP,
        ST_WALK,
        ST_SWAP_RDB,
        ST_SWAP_WRA,
        ST_SWAP_WRB,
        ST_DONE
    } state_t;

    localparam logic [3:0] LIM_ROWS = 4'(MAX_ROWS);
    localparam logic [3:0] LIM_COLS = 4'(MAX_COLS);

    state_t                 state_reg, state_next;
    logic [2:0]             row_reg, row_next;
    logic [2:0]             col_reg, col_next;
    logic [3:0]             lim_rows_reg, lim_rows_next;
    logic [3:0]             lim_cols_reg, lim_cols_next;
    logic                   more_reg, more_next;
    logic                   p_valid_reg, p_valid_next;
    logic [2:0]             p_row_reg, p_row_next;
    logic [2:0]             p_col_reg, p_col_next;
    sgtm_pkg::walk_mode_t   mode_reg, mode_next;

    logic col_wrap;
    logic row_last;
    logic adv;

    assign col_wrap = (({1'b0, col_reg} + 4'd1) == lim_cols_reg);
    assign row_last = (({1'b0, row_reg} + 4'd1) == lim_rows_reg);
    assign adv      = !p_valid_reg || status.out_free;

    // Next state and commands
    always_comb begin
        state_next    = state_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        lim_rows_next = lim_rows_reg;
        lim_cols_next = lim_cols_reg;
        more_next     = more_reg;
        p_valid_next  = p_valid_reg;
        p_row_next    = p_row_reg;
        p_col_next    = p_col_reg;
        mode_next     = mode_reg;

        cmd           = '0;
        cmd.row       = row_reg;
        cmd.col       = col_reg;
        cmd.p_row     = p_row_reg;
        cmd.p_col     = p_col_reg;
        cmd.mode      = mode_reg;
        cmd.swap      = sgtm_pkg::SW_NONE;
        s_tready      = (state_reg == ST_IDLE);

        case (state_reg)
            // fill the whole memory, one entry a cycle
            ST_INIT, ST_SWEEP: begin
                cmd.wr_fill   = 1'b1;
                cmd.fill_zero = (state_reg == ST_INIT);
                if (col_wrap) begin
                    col_next = 3'd0;
                    row_next = row_reg + 3'd1;
                    if (row_last) begin
                        state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_DONE;
                    end
                end else begin
                    col_next = col_reg + 3'd1;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                p_valid_next = 1'b0;
                case (status.op)
                    sgtm_pkg::OP_CLEAR: begin
                        cmd.latch_cfg = 1'b1;
                        row_next      = 3'd0;
                        col_next      = 3'd0;
                        lim_rows_next = LIM_ROWS;
                        lim_cols_next = LIM_COLS;
                        state_next    = status.cfg_ok ? ST_SWEEP : ST_DONE;
                    end
                    sgtm_pkg::OP_UPDATE: begin
                        // a walk of one entry: limits end right after it
                        row_next      = status.row_a;
                        col_next      = status.col_a;
                        lim_rows_next = {1'b0, status.row_a} + 4'd1;
                        lim_cols_next = {1'b0, status.col_a} + 4'd1;
                        more_next     = status.a_in;
                        mode_next     = sgtm_pkg::WM_UPDATE;
                        state_next    = ST_WALK;
                    end
                    sgtm_pkg::OP_TICK, sgtm_pkg::OP_SCAN: begin
                        row_next      = 3'd0;
                        col_next      = 3'd0;
                        lim_rows_next = status.g_rows;
                        lim_cols_next = status.g_cols;
                        more_next     = (status.g_rows != 4'd0) && (status.g_cols != 4'd0);
                        mode_next     = (status.op == sgtm_pkg::OP_TICK) ?
                                        sgtm_pkg::WM_TICK : sgtm_pkg::WM_SCAN;
                        state_next    = ST_WALK;
                    end
                    sgtm_pkg::OP_SWAP: begin
                        if (status.a_in && status.b_in) begin
                            cmd.swap   = sgtm_pkg::SW_RDA;
                            state_next = ST_SWAP_RDB;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            // read one entry a cycle and process it from the registered read data; both hold on output stall
            ST_WALK: begin
                if (adv) begin
                    cmd.proc = p_valid_reg;
                    if (more_reg) begin
                        cmd.rd_en    = 1'b1;
                        p_valid_next = 1'b1;
                        p_row_next   = row_reg;
                        p_col_next   = col_reg;
                        if (col_wrap) begin
                            col_next = 3'd0;
                            row_next = row_reg + 3'd1;
                            if (row_last) begin
                                more_next = 1'b0;
                            end
                        end else begin
                            col_next = col_reg + 3'd1;
                        end
                    end else begin
                        p_valid_next = 1'b0;
                        if (!p_valid_reg) begin
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_SWAP_RDB: begin
                cmd.swap   = sgtm_pkg::SW_RDB;
                state_next = ST_SWAP_WRA;
            end
            ST_SWAP_WRA: begin
                cmd.swap   = sgtm_pkg::SW_WRA;
                state_next = ST_SWAP_WRB;
            end
            ST_SWAP_WRB: begin
                cmd.swap   = sgtm_pkg::SW_WRB;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.emit_done = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            row_reg      <= 3'd0;
            col_reg      <= 3'd0;
            lim_rows_reg <= LIM_ROWS;
            lim_cols_reg <= LIM_COLS;
            more_reg     <= 1'b0;
            p_valid_reg  <= 1'b0;
            p_row_reg    <= 3'd0;
            p_col_reg    <= 3'd0;
            mode_reg     <= sgtm_pkg::WM_SCAN;
        end else begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            lim_rows_reg <= lim_rows_next;
            lim_cols_reg <= lim_cols_next;
            more_reg     <= more_next;
            p_valid_reg  <= p_valid_next;
            p_row_reg    <= p_row_next;
            p_col_reg    <= p_col_next;
            mode_reg     <= mode_next;
        end
    end

endmodule

// ===== hdl/sgtm_dp.sv =====
module sgtm_dp #(
    parameter int MAX_ROWS = 4,
    parameter int MAX_COLS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_wr_data,
    input  logic [31:0]       s_tdata,
    input  logic [2:0]        s_tuser,
    input  sgtm_pkg::cmd_t    cmd,
    output sgtm_pkg::status_t status,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);

    localparam int DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ENTRY_W = $bits(sgtm_pkg::entry_t);
    localparam logic RESET_FITS = (int'(sgtm_pkg::RESET_ROWS) <= MAX_ROWS)
                               && (int'(sgtm_pkg::RESET_COLS) <= MAX_COLS);

    function automatic logic [ADDR_W-1:0] addr_of(input logic [2:0] r, input logic [2:0] c);
        addr_of = ADDR_W'(32'(r) * MAX_COLS + 32'(c));
    endfunction

    // Configuration registers
    logic signed [15:0] low_reg, high_reg, start_reg;
    logic [5:0]         idle_reg;
    logic [2:0]         rows_reg;
    logic [3:0]         cols_reg;

    // Grid settings latched by clear
    logic signed [15:0] g_low_reg, g_high_reg;
    logic [5:0]         g_idle_reg;
    logic [3:0]         g_rows_reg, g_cols_reg;

    // Captured input item
    sgtm_pkg::op_t      op_reg;
    logic [2:0]         ra_reg, ca_reg, rb_reg, cb_reg;
    logic signed [15:0] reading_reg;

    // Output register
    logic               m_valid_reg, m_valid_next;
    sgtm_pkg::kind_t    m_kind_reg;
    logic [2:0]         m_row_reg, m_col_reg;
    logic signed [15:0] m_temp_reg;
    logic               m_ok_reg, m_last_reg;

    sgtm_pkg::entry_t   hold_reg;
    sgtm_pkg::entry_t   ent;
    sgtm_pkg::entry_t   proc_data;
    sgtm_pkg::entry_t   fill_data;
    logic [ENTRY_W-1:0] rd_data;
    logic [ENTRY_W-1:0] wr_data;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;
    logic               wr_en, rd_en;
    logic               proc_wr;
    logic               alert_hit;
    sgtm_pkg::kind_t    alert_kind;
    logic [5:0]         idle_inc;
    logic               cfg_ok;
    logic               a_in, b_in;
    logic               out_free;
    logic               swap_ok;

    // Clear check on the current register values
    assign cfg_ok = !(low_reg > high_reg)
                 && !(low_reg < sgtm_pkg::TEMP_MIN) && !(low_reg > sgtm_pkg::TEMP_MAX)
                 && !(high_reg < sgtm_pkg::TEMP_MIN) && !(high_reg > sgtm_pkg::TEMP_MAX)
                 && !(start_reg < sgtm_pkg::TEMP_MIN) && !(start_reg > sgtm_pkg::TEMP_MAX)
                 && !(idle_reg > sgtm_pkg::IDLE_MAX)
                 && (rows_reg != 3'd0) && (cols_reg != 4'd0)
                 && (32'(rows_reg) <= MAX_ROWS) && (32'(cols_reg) <= MAX_COLS);

    assign a_in     = ({1'b0, ra_reg} < g_rows_reg) && ({1'b0, ca_reg} < g_cols_reg);
    assign b_in     = ({1'b0, rb_reg} < g_rows_reg) && ({1'b0, cb_reg} < g_cols_reg);
    assign out_free = !m_valid_reg || m_tready;
    assign swap_ok  = (op_reg == sgtm_pkg::OP_SWAP) && a_in && b_in;

    always_comb begin
        status          = '0;
        status.out_free = out_free;
        status.cfg_ok   = cfg_ok;
        status.op       = op_reg;
        status.a_in     = a_in;
        status.b_in     = b_in;
        status.row_a    = ra_reg;
        status.col_a    = ca_reg;
        status.g_rows   = g_rows_reg;
        status.g_cols   = g_cols_reg;
    end

    // Configuration writes, settings latch and item capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg    <= sgtm_pkg::RESET_LOW;
            high_reg   <= sgtm_pkg::RESET_HIGH;
            idle_reg   <= sgtm_pkg::RESET_IDLE;
            start_reg  <= sgtm_pkg::RESET_START;
            rows_reg   <= sgtm_pkg::RESET_ROWS;
            cols_reg   <= sgtm_pkg::RESET_COLS;
            g_low_reg  <= sgtm_pkg::RESET_LOW;
            g_high_reg <= sgtm_pkg::RESET_HIGH;
            g_idle_reg <= sgtm_pkg::RESET_IDLE;
            g_rows_reg <= RESET_FITS ? {1'b0, sgtm_pkg::RESET_ROWS} : 4'd0;
            g_cols_reg <= RESET_FITS ? sgtm_pkg::RESET_COLS : 4'd0;
        end else begin
            if (cfg_wr_en) begin
                case (sgtm_pkg::reg_idx_t'(cfg_index))
                    sgtm_pkg::REG_LOW_LIMIT:  low_reg   <= cfg_wr_data;
                    sgtm_pkg::REG_HIGH_LIMIT: high_reg  <= cfg_wr_data;
                    sgtm_pkg::REG_IDLE_LIMIT: idle_reg  <= cfg_wr_data[5:0];
                    sgtm_pkg::REG_START_TEMP: start_reg <= cfg_wr_data;
                    sgtm_pkg::REG_GRID_ROWS:  rows_reg  <= cfg_wr_data[2:0];
                    sgtm_pkg::REG_GRID_COLS:  cols_reg  <= cfg_wr_data[3:0];
                    default: ;
                endcase
            end
            if (cmd.latch_cfg) begin
                if (cfg_ok) begin
                    g_low_reg  <= low_reg;
                    g_high_reg <= high_reg;
                    g_idle_reg <= idle_reg;
                    g_rows_reg <= {1'b0, rows_reg};
                    g_cols_reg <= cols_reg;
                end else begin
                    g_rows_reg <= 4'd0;
                    g_cols_reg <= 4'd0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg      <= sgtm_pkg::op_t'(s_tuser);
            ra_reg      <= s_tdata[2:0];
            ca_reg      <= s_tdata[5:3];
            reading_reg <= s_tdata[21:6];
            rb_reg      <= s_tdata[24:22];
            cb_reg      <= s_tdata[27:25];
        end
        if (cmd.swap == sgtm_pkg::SW_RDB) begin
            hold_reg <= sgtm_pkg::entry_t'(rd_data);
        end
    end

    // Per-entry processing of the registered read word
    assign ent      = sgtm_pkg::entry_t'(rd_data);
    assign idle_inc = ent.idle + 6'd1;

    always_comb begin
        proc_wr    = 1'b0;
        proc_data  = ent;
        alert_hit  = 1'b0;
        alert_kind = sgtm_pkg::KIND_DONE;
        case (cmd.mode)
            sgtm_pkg::WM_UPDATE: begin
                if (ent.active) begin
                    proc_wr        = 1'b1;
                    proc_data.idle = 6'd0;
                    proc_data.temp = reading_reg;
                    if (reading_reg > g_high_reg) begin
                        alert_hit  = 1'b1;
                        alert_kind = sgtm_pkg::KIND_HIGH;
                    end else if (reading_reg < g_low_reg) begin
                        alert_hit  = 1'b1;
                        alert_kind = sgtm_pkg::KIND_LOW;
                    end
                end
            end
            sgtm_pkg::WM_TICK: begin
                if (ent.active) begin
                    proc_wr        = 1'b1;
                    proc_data.idle = idle_inc;
                    if (idle_inc > g_idle_reg) begin
                        proc_data.active = 1'b0;
                        alert_hit        = 1'b1;
                        alert_kind       = sgtm_pkg::KIND_INACTIVE;
                    end
                end
            end
            sgtm_pkg::WM_SCAN: begin
                if (!ent.active) begin
                    alert_hit  = 1'b1;
                    alert_kind = sgtm_pkg::KIND_INACTIVE;
                end else if (ent.temp > g_high_reg) begin
                    alert_hit  = 1'b1;
                    alert_kind = sgtm_pkg::KIND_HIGH;
                end else if (ent.temp < g_low_reg) begin
                    alert_hit  = 1'b1;
                    alert_kind = sgtm_pkg::KIND_LOW;
                end
            end
            default: ;
        endcase
    end

    // Memory port selection
    assign fill_data.active = 1'b1;
    assign fill_data.idle   = 6'd0;
    assign fill_data.temp   = cmd.fill_zero ? sgtm_pkg::RESET_START : start_reg;

    always_comb begin
        rd_en   = cmd.rd_en;
        rd_addr = addr_of(cmd.row, cmd.col);
        if (cmd.swap == sgtm_pkg::SW_RDA) begin
            rd_en   = 1'b1;
            rd_addr = addr_of(ra_reg, ca_reg);
        end else if (cmd.swap == sgtm_pkg::SW_RDB) begin
            rd_en   = 1'b1;
            rd_addr = addr_of(rb_reg, cb_reg);
        end

        wr_en   = 1'b0;
        wr_addr = addr_of(cmd.row, cmd.col);
        wr_data = fill_data;
        if (cmd.wr_fill) begin
            wr_en = 1'b1;
        end else if (cmd.proc && proc_wr) begin
            wr_en   = 1'b1;
            wr_addr = addr_of(cmd.p_row, cmd.p_col);
            wr_data = proc_data;
        end else if (cmd.swap == sgtm_pkg::SW_WRA) begin
            wr_en   = 1'b1;
            wr_addr = addr_of(ra_reg, ca_reg);
            wr_data = rd_data;
        end else if (cmd.swap == sgtm_pkg::SW_WRB) begin
            wr_en   = 1'b1;
            wr_addr = addr_of(rb_reg, cb_reg);
            wr_data = hold_reg;
        end
    end

    sgtm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_sensor_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if ((cmd.proc && alert_hit) || cmd.emit_done) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_done) begin
            m_kind_reg <= sgtm_pkg::KIND_DONE;
            m_row_reg  <= 3'd0;
            m_col_reg  <= 3'd0;
            m_temp_reg <= 16'sd0;
            m_ok_reg   <= swap_ok;
            m_last_reg <= 1'b1;
        end else if (cmd.proc && alert_hit) begin
            m_kind_reg <= alert_kind;
            m_row_reg  <= cmd.p_row;
            m_col_reg  <= cmd.p_col;
            m_temp_reg <= proc_data.temp;
            m_ok_reg   <= 1'b0;
            m_last_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_ok_reg, m_temp_reg, m_col_reg, m_row_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule
